FILE: src/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // One stored pair; the key sits in the low half.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [KEY_W-1:0]   key;
    } entry_t;

    // Request sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY
    } state_t;

endpackage

FILE: src/lkvc_store.sv
// Key/value entry memory: one write port, one registered read port.
module lkvc_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output lkvc_pkg::entry_t    rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  lkvc_pkg::entry_t    wr_data
);

    lkvc_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: request sequencer, recency ranks and entry memory.
//
// Fully associative key/value store with least-recently-used replacement.
// Input channel s_axis: tuser carries the operation (0 get, 1 set), tdata carries
// the key in bits 31:0 and the value to store in bits 63:32. Output channel m_axis
// gives one transfer per request: tuser is the hit flag of a get (zero for every set),
// tdata the value read on a get hit (zero on a miss and for every set).
// cfg_we/cfg_wdata write the capacity register (entries in use before eviction).
// A zero capacity acts as one, a capacity above ENTRIES acts as ENTRIES.
// A request is handled in steps: it is accepted, every slot is streamed out of the
// entry memory through its single read port, the last compare is finished, and the
// entry, ranks and valid marks are written back.
// The next request is accepted as soon as the write-back is done, while the result
// still waits in the output register. If the receiver stalls, the block finishes
// the following request and then holds it in the write-back cycle until the output
// register is free.
// Reset clears all valid marks, ranks and the live count, and sets capacity to 16;
// the block is ready right after reset.
module lru_key_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,      // capacity
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
    input  logic        s_axis_tuser,   // [0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] read_value
    output logic        m_axis_tuser    // [0] hit
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    lkvc_pkg::state_t state_reg, state_next;

    logic [lkvc_pkg::CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0]           live_reg;
    logic [ENTRIES-1:0]         valid_reg;
    logic [IDX_W-1:0]           rank_reg [ENTRIES];

    // request
    logic                        mode_reg;
    logic [lkvc_pkg::KEY_W-1:0]   key_reg;
    logic [lkvc_pkg::VALUE_W-1:0] value_reg;

    // scan
    logic [IDX_W-1:0] scan_idx_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    lkvc_pkg::entry_t rd_data;

    logic                         hit_found_reg;
    logic [IDX_W-1:0]             hit_slot_reg;
    logic [IDX_W-1:0]             hit_rank_reg;
    logic [lkvc_pkg::VALUE_W-1:0] hit_value_reg;
    logic                         old_found_reg;
    logic [IDX_W-1:0]             old_slot_reg;
    logic [IDX_W-1:0]             old_rank_reg;
    logic                         free_found_reg;
    logic [IDX_W-1:0]             free_slot_reg;

    // output register
    logic                         out_valid_reg;
    logic                         out_hit_reg;
    logic [lkvc_pkg::VALUE_W-1:0] out_value_reg;

    // sequencer outputs
    logic in_fire;
    logic rd_en;
    logic apply_go;

    // write-back decisions
    logic [CMP_W-1:0]             eff_cap;
    logic                         do_touch;
    logic                         touch_all;
    logic [IDX_W-1:0]             touch_thr;
    logic [IDX_W-1:0]             tgt_slot;
    logic                         mem_we;
    logic                         fill;
    logic                         res_hit;
    logic [lkvc_pkg::VALUE_W-1:0] res_value;

    // cmp stage
    logic             cmp_valid_entry;
    logic [IDX_W-1:0] cmp_rank;

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = lkvc_pkg::ST_DRAIN;
                end
            end
            lkvc_pkg::ST_DRAIN:
            begin
                state_next = lkvc_pkg::ST_APPLY;
            end
            lkvc_pkg::ST_APPLY:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = lkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == lkvc_pkg::ST_IDLE);
        rd_en         = (state_reg == lkvc_pkg::ST_SCAN);
        apply_go      = (state_reg == lkvc_pkg::ST_APPLY) && (!out_valid_reg || m_axis_tready);
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkvc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        eff_cap = CMP_W'(capacity_reg);
        if (capacity_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
    end

    // ---------------------------------------------------------------- request capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= s_axis_tuser;
            key_reg   <= s_axis_tdata[31:0];
            value_reg <= s_axis_tdata[63:32];
        end
    end

    // ---------------------------------------------------------------- scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
        end
        else
        begin
            cmp_vld_reg <= rd_en;
            cmp_idx_reg <= scan_idx_reg;
            if (in_fire)
            begin
                scan_idx_reg <= '0;
            end
            else if (rd_en)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    lkvc_store #(
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (tgt_slot),
        .wr_data ({value_reg, key_reg})
    );

    assign cmp_valid_entry = valid_reg[cmp_idx_reg];
    assign cmp_rank        = rank_reg[cmp_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            old_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            hit_found_reg  <= 1'b0;
            old_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmp_vld_reg)
        begin
            if (cmp_valid_entry && (rd_data.key == key_reg))
            begin
                hit_found_reg <= 1'b1;
            end
            if (cmp_valid_entry && (!old_found_reg || (cmp_rank > old_rank_reg)))
            begin
                old_found_reg <= 1'b1;
            end
            if (!cmp_valid_entry)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_vld_reg)
        begin
            if (cmp_valid_entry && (rd_data.key == key_reg))
            begin
                hit_slot_reg  <= cmp_idx_reg;
                hit_rank_reg  <= cmp_rank;
                hit_value_reg <= rd_data.value;
            end
            if (cmp_valid_entry && (!old_found_reg || (cmp_rank > old_rank_reg)))
            begin
                old_slot_reg <= cmp_idx_reg;
                old_rank_reg <= cmp_rank;
            end
            // keep the lowest free slot
            if (!cmp_valid_entry && !free_found_reg)
            begin
                free_slot_reg <= cmp_idx_reg;
            end
        end
    end

    // ---------------------------------------------------------------- write-back
    always_comb
    begin
        do_touch  = 1'b0;
        touch_all = 1'b0;
        touch_thr = hit_rank_reg;
        tgt_slot  = hit_slot_reg;
        mem_we    = 1'b0;
        fill      = 1'b0;
        res_hit   = 1'b0;
        res_value = '0;
        if (!mode_reg)
        begin
            if (hit_found_reg)
            begin
                res_hit   = 1'b1;
                res_value = hit_value_reg;
                do_touch  = apply_go;
            end
        end
        else if (hit_found_reg)
        begin
            mem_we   = apply_go;
            do_touch = apply_go;
        end
        else if ((CMP_W'(live_reg) < eff_cap) && free_found_reg)
        begin
            // new entry: every live entry ages by one
            tgt_slot  = free_slot_reg;
            touch_all = 1'b1;
            mem_we    = apply_go;
            fill      = apply_go;
            do_touch  = apply_go;
        end
        else if (old_found_reg)
        begin
            tgt_slot  = old_slot_reg;
            touch_thr = old_rank_reg;
            mem_we    = apply_go;
            do_touch  = apply_go;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            live_reg  <= '0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            if (fill)
            begin
                valid_reg[tgt_slot] <= 1'b1;
                live_reg            <= live_reg + CNT_W'(1);
            end
            if (do_touch)
            begin
                for (int j = 0; j < ENTRIES; j++)
                begin
                    if (IDX_W'(j) == tgt_slot)
                    begin
                        rank_reg[j] <= '0;
                    end
                    else if (valid_reg[j] && (touch_all || (rank_reg[j] < touch_thr)))
                    begin
                        rank_reg[j] <= rank_reg[j] + IDX_W'(1);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (apply_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_go)
        begin
            out_hit_reg   <= res_hit;
            out_value_reg <= res_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = out_value_reg;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the LRU key-value cache core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam bit OP_GET = 1'b0;
    localparam bit OP_SET = 1'b1;

    typedef struct packed {
        bit                           mode;
        logic [lkvc_pkg::KEY_W-1:0]   key;
        logic [lkvc_pkg::VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic                         hit;
        logic [lkvc_pkg::VALUE_W-1:0] read_value;
    } answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0] cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [63:0]        s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [31:0]        m_axis_tdata;
    logic               m_axis_tuser;

    logic               hold_off = 1'b0;

    // Cache contents as predicted
    bit [lkvc_pkg::KEY_W-1:0]   slot_key [SLOTS];
    bit [lkvc_pkg::VALUE_W-1:0] slot_val [SLOTS];
    bit                 slot_live [SLOTS];
    int unsigned        slot_age [SLOTS];
    int unsigned        live_cnt = 0;
    logic [lkvc_pkg::CAP_W-1:0] cap_setting = lkvc_pkg::CAP_RESET;

    request_t           pending_reqs[$];
    answer_t            expected_answers[$];

    int                 errors = 0;
    int                 n_accepted = 0;
    int                 n_gets = 0;
    int                 n_hits = 0;
    int                 n_evicts = 0;
    int                 n_cfg = 0;

    int                 burst_left = 0;
    int                 gap_left = 0;
    int                 stall_left = 0;
    int                 run_left = 0;

    lru_key_value_cache_core #(
        .ENTRIES(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= 100)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Make a live slot the most recent; younger slots age by one.
    function automatic void promote(int s);
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_age[i] < slot_age[s])
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic answer_t cache_apply(request_t req);
        answer_t     ans;
        int          hit_slot;
        int          free_slot;
        int          old_slot;
        int unsigned room;
        ans = '0;
        hit_slot = -1;
        free_slot = -1;
        old_slot = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit_slot < 0 && slot_live[i] && slot_key[i] == req.key)
                hit_slot = i;
            if (free_slot < 0 && !slot_live[i])
                free_slot = i;
            if (slot_live[i] && (old_slot < 0 || slot_age[i] > slot_age[old_slot]))
                old_slot = i;
        end
        room = (cap_setting == 0) ? 1 : ((cap_setting > SLOTS) ? SLOTS : cap_setting);
        if (req.mode == OP_GET)
        begin
            n_gets++;
            if (hit_slot >= 0)
            begin
                ans.hit = 1'b1;
                ans.read_value = slot_val[hit_slot];
                promote(hit_slot);
                n_hits++;
            end
        end
        else if (hit_slot >= 0)
        begin
            slot_val[hit_slot] = req.value;
            promote(hit_slot);
        end
        else if (live_cnt < room && free_slot >= 0)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_live[i])
                    slot_age[i]++;
            slot_live[free_slot] = 1'b1;
            slot_key[free_slot] = req.key;
            slot_val[free_slot] = req.value;
            slot_age[free_slot] = 0;
            live_cnt++;
        end
        else if (old_slot >= 0)
        begin
            slot_key[old_slot] = req.key;
            slot_val[old_slot] = req.value;
            promote(old_slot);
            n_evicts++;
        end
        return ans;
    endfunction

    // Request driver: bursts of transfers separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_answers.push_back(cache_apply(pending_reqs.pop_front()));
                n_accepted++;
            end
            // Hold an offered item until it is taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_reqs[0].value, pending_reqs[0].key};
                    s_axis_tuser <= pending_reqs[0].mode;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 7);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge clk)
    begin
        answer_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            run_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("result transfer with no request outstanding");
                else
                begin
                    want = expected_answers.pop_front();
                    if (m_axis_tuser !== want.hit)
                        report_mismatch($sformatf("hit %b, expected %b",
                                                  m_axis_tuser, want.hit));
                    if (m_axis_tdata !== want.read_value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  m_axis_tdata, want.read_value));
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (run_left > 0)
                run_left--;
            else
            begin
                run_left = $urandom_range(0, 40);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
            m_axis_tready <= !hold_off && (stall_left == 0);
        end
    end

    // Long receiver hold-off while requests keep coming, to back up the input
    initial
    begin
        do @(negedge clk); while (n_accepted < 400 || pending_reqs.size() < 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic queue_request(bit mode, logic [31:0] key, logic [31:0] value);
        request_t r;
        r.mode = mode;
        r.key = key;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    task automatic drain;
        do @(negedge clk); while (pending_reqs.size() != 0 || expected_answers.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        cap_setting = c;
        n_cfg++;
    endtask

    initial
    begin
        logic [lkvc_pkg::CAP_W-1:0] phase_caps [10];
        logic [31:0]      pool [24];
        int               pool_n;
        logic [31:0]      k;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty lookup, extreme keys and values, update, ignored get value
        queue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
        queue_request(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
        queue_request(OP_SET, 32'h0000_0000, 32'hffff_ffff);
        queue_request(OP_SET, 32'hffff_ffff, 32'h0000_0000);
        queue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
        queue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(OP_GET, 32'hffff_ffff, 32'h0000_0000);
        queue_request(OP_SET, 32'h0000_0000, 32'h0000_5a5a);
        queue_request(OP_GET, 32'h0000_0000, 32'hffff_ffff);
        queue_request(OP_GET, 32'h1234_5678, 32'hdead_beef);
        drain();

        // Capacity dropped below the live count: sets on new keys replace the oldest
        write_capacity(5'd2);
        queue_request(OP_SET, 32'h0000_0011, 32'h0000_0001);
        queue_request(OP_GET, 32'h0000_0011, 32'h0000_0000);
        queue_request(OP_SET, 32'h0000_0022, 32'h0000_0002);
        queue_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(OP_GET, 32'h0000_0022, 32'h0000_0000);
        drain();

        // Zero capacity acts as one
        write_capacity(5'd0);
        queue_request(OP_SET, 32'h0000_0033, 32'h0000_0003);
        queue_request(OP_GET, 32'h0000_0033, 32'h0000_0000);
        queue_request(OP_GET, 32'h0000_0022, 32'h0000_0000);
        drain();

        // Capacity above the slot count saturates
        write_capacity(5'd31);
        queue_request(OP_SET, 32'h0000_0044, 32'h0000_0004);
        queue_request(OP_GET, 32'h0000_0044, 32'h0000_0000);
        drain();

        phase_caps[0] = 5'd8;
        phase_caps[1] = 5'd16;
        phase_caps[2] = 5'd1;
        phase_caps[3] = 5'd0;
        phase_caps[4] = 5'd31;
        phase_caps[5] = 5'd17;
        phase_caps[6] = 5'd3;
        phase_caps[7] = 5'($urandom_range(1, 16));
        phase_caps[8] = 5'd16;
        phase_caps[9] = 5'($urandom_range(0, 31));

        // Random: mostly keys from a small per-phase pool so gets hit, some stray keys
        for (int p = 0; p < 10; p++)
        begin
            write_capacity(phase_caps[p]);
            pool_n = $urandom_range(2, 24);
            for (int i = 0; i < pool_n; i++)
                pool[i] = $urandom;
            for (int n = 0; n < 143; n++)
            begin
                k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)]
                                                 : $urandom;
                queue_request(bit'($urandom_range(0, 1)), k, $urandom);
            end
            drain();
        end

        repeat (40) @(posedge clk);
        $display("Covered %0d requests: %0d gets with %0d hits, %0d evictions",
                 n_accepted, n_gets, n_hits, n_evicts);
        $display("Capacity written %0d times, including zero, one and saturated values", n_cfg);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
src/lkvc_pkg.sv
src/lkvc_store.sv
src/lru_key_value_cache_core.sv
verif/tb.sv
